// File: rtl/partition_allocator_fit_assert.svh
// Assertion macros for the partition allocator checker.
`ifndef PARTITION_ALLOCATOR_FIT_ASSERT_SVH
`define PARTITION_ALLOCATOR_FIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PAF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("partition allocator check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PAF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("partition allocator check failed");

`endif

// File: rtl/pafit_pkg.sv
package pafit_pkg;

  localparam int UNIT_W     = 10;
  localparam int PIDX_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int MODE_W     = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_SIZE   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_SPACE   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BAD_INDEX  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 3'd4;

  typedef struct packed {
    logic              busy;
    logic [UNIT_W-1:0] len;
    logic [UNIT_W-1:0] start;
  } part_t;

  typedef struct packed {
    logic              clear;
    logic              valid;
    logic [MODE_W-1:0] mode;
  } pick_ctl_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [12:0] {
    S_INIT     = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_SCAN     = 13'b0000000000100,
    S_DECIDE   = 13'b0000000001000,
    S_SHIFT    = 13'b0000000010000,
    S_SPLIT_HI = 13'b0000000100000,
    S_SPLIT_LO = 13'b0000001000000,
    S_FR_OPEN  = 13'b0000010000000,
    S_FR_LEFT  = 13'b0000100000000,
    S_FR_RIGHT = 13'b0001000000000,
    S_FR_WRITE = 13'b0010000000000,
    S_COMPACT  = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

endpackage

// File: rtl/pafit_ram.sv
module pafit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/pafit_alu.sv
module pafit_alu (
  input  pafit_pkg::alu_op_t          op,
  input  logic [pafit_pkg::UNIT_W-1:0] a,
  input  logic [pafit_pkg::UNIT_W-1:0] b,
  output logic [pafit_pkg::UNIT_W-1:0] y
);

  always_comb begin
    case (op)
      pafit_pkg::ALU_ADD: y = a + b;
      pafit_pkg::ALU_SUB: y = a - b;
      default:            y = a + b;
    endcase
  end

endmodule

// File: rtl/pafit_pick.sv
module pafit_pick #(
  parameter int IDX_W = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pafit_pkg::pick_ctl_t          ctl,
  input  pafit_pkg::part_t              ent,
  input  logic [IDX_W-1:0]              ent_idx,
  input  logic [pafit_pkg::UNIT_W-1:0]  req,
  output logic                          found,
  output logic [IDX_W-1:0]              pick_idx,
  output pafit_pkg::part_t              pick_ent
);

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  pafit_pkg::part_t ent_r, ent_nxt;
  logic             cand;
  logic             take;

  always_comb begin
    cand = ctl.valid && !ent.busy && (ent.len >= req);
    take = cand && (!found_r ||
                    ((ctl.mode == pafit_pkg::FIT_BEST)  && (ent.len < ent_r.len)) ||
                    ((ctl.mode == pafit_pkg::FIT_WORST) && (ent.len > ent_r.len)));
    found_nxt = found_r;
    idx_nxt   = idx_r;
    ent_nxt   = ent_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
      idx_nxt   = ent_idx;
      ent_nxt   = ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    idx_r <= idx_nxt;
    ent_r <= ent_nxt;
  end

  assign found    = found_r;
  assign pick_idx = idx_r;
  assign pick_ent = ent_r;

endmodule

// File: rtl/partition_allocator_fit.sv
// Channel  Ports                         Dir  Fields (lowest bit up)
// in       in_tvalid/in_tready           in   tdata: alloc_size, partition_index
//                                             tuser: command
// out      out_tvalid/out_tready         out  tdata: region_address, region_index,
//                                                    region_size; tuser: status
// cfg      cfg_valid/cfg_ready           in   data: fit_mode
//
// One request at a time; in_tready is high only while idle.
// Allocate: scans one entry per cycle, then decides; on a split it shifts the later
// entries up to open a slot and writes both halves, then loads the result word.
// Free: reads neighbors on each side, merging free ones and stopping at the first busy one
// per side, writes the merged entry and loads the result word; a merge moves later entries down.
// After reset entry 0 is seeded before idle; a result waiting on out_tready holds the block.
module partition_allocator_fit #(
  parameter int MEM_UNITS = 640,
  parameter int MAX_PARTS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [pafit_pkg::IN_DATA_W-1:0]      in_tdata,   // alloc_size, partition_index
  input  logic [0:0]                           in_tuser,   // command
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [pafit_pkg::OUT_DATA_W-1:0]     out_tdata,  // address, index, size
  output logic [pafit_pkg::STATUS_W-1:0]       out_tuser,  // status
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pafit_pkg::MODE_W-1:0]         cfg_data    // fit_mode
);

  localparam int IW = $clog2(MAX_PARTS);
  localparam int CW = $clog2(MAX_PARTS + 1);
  localparam int UW = pafit_pkg::UNIT_W;
  localparam int PW = pafit_pkg::PIDX_W;

  pafit_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [pafit_pkg::MODE_W-1:0]     fit_mode_r, fit_mode_nxt;
  logic [UW-1:0]                    req_r, req_nxt;
  logic [PW-1:0]                    idx_r, idx_nxt;
  logic [CW-1:0]                    ptr_r, ptr_nxt;
  logic [IW-1:0]                    wptr_r, wptr_nxt;
  logic                             pend_r, pend_nxt;
  logic [UW-1:0]                    sum_r, sum_nxt;
  logic [UW-1:0]                    start_r, start_nxt;
  logic [IW-1:0]                    lo_r, lo_nxt;
  logic [CW-1:0]                    src_r, src_nxt;
  logic [CW-1:0]                    gap_r, gap_nxt;
  logic [UW-1:0]                    tail_r, tail_nxt;
  logic [IW-1:0]                    didx_r, didx_nxt;
  logic [pafit_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [UW-1:0]                    res_addr_r, res_addr_nxt;
  logic [PW-1:0]                    res_idx_r, res_idx_nxt;
  logic [UW-1:0]                    res_size_r, res_size_nxt;
  logic                             out_tvalid_r, out_tvalid_nxt;
  logic [pafit_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [pafit_pkg::STATUS_W-1:0]   out_tuser_r, out_tuser_nxt;

  logic                     ram_we;
  logic [IW-1:0]            ram_waddr;
  pafit_pkg::part_t         ram_wdata;
  logic [IW-1:0]            ram_raddr;
  logic [$bits(pafit_pkg::part_t)-1:0] ram_rdata;
  pafit_pkg::part_t         rd_q;

  pafit_pkg::pick_ctl_t     pick_ctl;
  logic                     pick_found;
  logic [IW-1:0]            pick_idx;
  pafit_pkg::part_t         pick_ent;

  pafit_pkg::alu_op_t       alu_op;
  logic [UW-1:0]            alu_a;
  logic [UW-1:0]            alu_b;
  logic [UW-1:0]            alu_y;

  logic [UW-1:0]            in_size;
  logic [PW-1:0]            in_pidx;
  logic [CW-1:0]            ptr_inc;
  logic [CW-1:0]            ptr_dec;
  logic [CW-1:0]            idx_ext;
  logic [CW-1:0]            idx_inc;
  logic [CW-1:0]            ptr_back;
  logic [CW-1:0]            gap_calc;

  assign rd_q     = pafit_pkg::part_t'(ram_rdata);
  assign in_size  = in_tdata[UW-1:0];
  assign in_pidx  = in_tdata[UW+PW-1:UW];
  assign ptr_inc  = ptr_r + 1'b1;
  assign ptr_dec  = ptr_r - 1'b1;
  assign idx_ext  = CW'(idx_r);
  assign idx_inc  = idx_ext + 1'b1;
  assign ptr_back = ptr_r - gap_r;
  assign gap_calc = src_r - CW'(lo_r) - 1'b1;

  pafit_ram #(
    .WIDTH($bits(pafit_pkg::part_t)),
    .DEPTH(MAX_PARTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pafit_pick #(
    .IDX_W(IW)
  ) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (pick_ctl),
    .ent      (rd_q),
    .ent_idx  (didx_r),
    .req      (req_r),
    .found    (pick_found),
    .pick_idx (pick_idx),
    .pick_ent (pick_ent)
  );

  pafit_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fit_mode_nxt   = fit_mode_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    ptr_nxt        = ptr_r;
    wptr_nxt       = wptr_r;
    pend_nxt       = pend_r;
    sum_nxt        = sum_r;
    start_nxt      = start_r;
    lo_nxt         = lo_r;
    src_nxt        = src_r;
    gap_nxt        = gap_r;
    tail_nxt       = tail_r;
    didx_nxt       = didx_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_idx_nxt    = res_idx_r;
    res_size_nxt   = res_size_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    pick_ctl.clear = 1'b0;
    pick_ctl.valid = 1'b0;
    pick_ctl.mode  = fit_mode_r;

    alu_op = pafit_pkg::ALU_ADD;
    alu_a  = sum_r;
    alu_b  = rd_q.len;

    if (cfg_valid) begin
      fit_mode_nxt = cfg_data;
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      pafit_pkg::S_INIT: begin
        ram_we          = 1'b1;
        ram_waddr       = '0;
        ram_wdata.busy  = 1'b0;
        ram_wdata.len   = UW'(MEM_UNITS);
        ram_wdata.start = '0;
        state_nxt       = pafit_pkg::S_IDLE;
      end

      pafit_pkg::S_IDLE: begin
        ram_raddr = IW'(in_pidx);
        if (in_tvalid) begin
          req_nxt      = in_size;
          idx_nxt      = in_pidx;
          res_addr_nxt = '0;
          res_idx_nxt  = '0;
          res_size_nxt = '0;
          if (in_tuser[0] == pafit_pkg::CMD_ALLOC) begin
            if ((in_size == '0) || (in_size > UW'(MEM_UNITS))) begin
              res_status_nxt = pafit_pkg::STAT_BAD_SIZE;
              state_nxt      = pafit_pkg::S_DONE;
            end else begin
              pick_ctl.clear = 1'b1;
              ptr_nxt        = '0;
              pend_nxt       = 1'b0;
              state_nxt      = pafit_pkg::S_SCAN;
            end
          end else begin
            if (8'(in_pidx) >= 8'(cnt_r)) begin
              res_status_nxt = pafit_pkg::STAT_BAD_INDEX;
              state_nxt      = pafit_pkg::S_DONE;
            end else begin
              state_nxt = pafit_pkg::S_FR_OPEN;
            end
          end
        end
      end

      pafit_pkg::S_SCAN: begin
        pick_ctl.valid = pend_r;
        if (ptr_r < cnt_r) begin
          ram_raddr = ptr_r[IW-1:0];
          didx_nxt  = ptr_r[IW-1:0];
          ptr_nxt   = ptr_inc;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = pafit_pkg::S_DECIDE;
          end
        end
      end

      pafit_pkg::S_DECIDE: begin
        alu_op   = pafit_pkg::ALU_SUB;
        alu_a    = pick_ent.len;
        alu_b    = req_r;
        tail_nxt = alu_y;
        if (!pick_found) begin
          res_status_nxt = pafit_pkg::STAT_NO_SPACE;
          state_nxt      = pafit_pkg::S_DONE;
        end else if (alu_y == '0) begin
          ram_we          = 1'b1;
          ram_waddr       = pick_idx;
          ram_wdata       = pick_ent;
          ram_wdata.busy  = 1'b1;
          res_status_nxt  = pafit_pkg::STAT_OK;
          res_addr_nxt    = pick_ent.start;
          res_idx_nxt     = PW'(pick_idx);
          res_size_nxt    = req_r;
          state_nxt       = pafit_pkg::S_DONE;
        end else if (cnt_r == CW'(MAX_PARTS)) begin
          res_status_nxt = pafit_pkg::STAT_TABLE_FULL;
          state_nxt      = pafit_pkg::S_DONE;
        end else begin
          ptr_nxt   = cnt_r - 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = pafit_pkg::S_SHIFT;
        end
      end

      pafit_pkg::S_SHIFT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wptr_r;
          ram_wdata = rd_q;
        end
        if (ptr_r > CW'(pick_idx)) begin
          ram_raddr = ptr_r[IW-1:0];
          wptr_nxt  = ptr_inc[IW-1:0];
          ptr_nxt   = ptr_dec;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = pafit_pkg::S_SPLIT_HI;
          end
        end
      end

      pafit_pkg::S_SPLIT_HI: begin
        alu_op          = pafit_pkg::ALU_ADD;
        alu_a           = pick_ent.start;
        alu_b           = req_r;
        ram_we          = 1'b1;
        ram_waddr       = pick_idx + 1'b1;
        ram_wdata.busy  = 1'b0;
        ram_wdata.len   = tail_r;
        ram_wdata.start = alu_y;
        state_nxt       = pafit_pkg::S_SPLIT_LO;
      end

      pafit_pkg::S_SPLIT_LO: begin
        ram_we          = 1'b1;
        ram_waddr       = pick_idx;
        ram_wdata.busy  = 1'b1;
        ram_wdata.len   = req_r;
        ram_wdata.start = pick_ent.start;
        cnt_nxt         = cnt_r + 1'b1;
        res_status_nxt  = pafit_pkg::STAT_OK;
        res_addr_nxt    = pick_ent.start;
        res_idx_nxt     = PW'(pick_idx);
        res_size_nxt    = req_r;
        state_nxt       = pafit_pkg::S_DONE;
      end

      pafit_pkg::S_FR_OPEN: begin
        sum_nxt   = rd_q.len;
        start_nxt = rd_q.start;
        lo_nxt    = IW'(idx_r);
        src_nxt   = idx_inc;
        if (idx_r != '0) begin
          ram_raddr = IW'(idx_r - 1'b1);
          ptr_nxt   = idx_ext - 1'b1;
          state_nxt = pafit_pkg::S_FR_LEFT;
        end else if (idx_inc < cnt_r) begin
          ram_raddr = idx_inc[IW-1:0];
          ptr_nxt   = idx_inc;
          state_nxt = pafit_pkg::S_FR_RIGHT;
        end else begin
          state_nxt = pafit_pkg::S_FR_WRITE;
        end
      end

      pafit_pkg::S_FR_LEFT: begin
        if (!rd_q.busy && (ptr_r != '0)) begin
          sum_nxt   = alu_y;
          start_nxt = rd_q.start;
          lo_nxt    = ptr_r[IW-1:0];
          ram_raddr = ptr_dec[IW-1:0];
          ptr_nxt   = ptr_dec;
        end else begin
          if (!rd_q.busy) begin
            sum_nxt   = alu_y;
            start_nxt = rd_q.start;
            lo_nxt    = ptr_r[IW-1:0];
          end
          if (idx_inc < cnt_r) begin
            ram_raddr = idx_inc[IW-1:0];
            ptr_nxt   = idx_inc;
            state_nxt = pafit_pkg::S_FR_RIGHT;
          end else begin
            state_nxt = pafit_pkg::S_FR_WRITE;
          end
        end
      end

      pafit_pkg::S_FR_RIGHT: begin
        if (!rd_q.busy) begin
          sum_nxt = alu_y;
          src_nxt = ptr_inc;
          if (ptr_inc < cnt_r) begin
            ram_raddr = ptr_inc[IW-1:0];
            ptr_nxt   = ptr_inc;
          end else begin
            state_nxt = pafit_pkg::S_FR_WRITE;
          end
        end else begin
          state_nxt = pafit_pkg::S_FR_WRITE;
        end
      end

      pafit_pkg::S_FR_WRITE: begin
        ram_we          = 1'b1;
        ram_waddr       = lo_r;
        ram_wdata.busy  = 1'b0;
        ram_wdata.len   = sum_r;
        ram_wdata.start = start_r;
        res_status_nxt  = pafit_pkg::STAT_OK;
        res_addr_nxt    = start_r;
        res_idx_nxt     = PW'(lo_r);
        res_size_nxt    = sum_r;
        gap_nxt         = gap_calc;
        if (gap_calc != '0) begin
          ptr_nxt   = src_r;
          pend_nxt  = 1'b0;
          state_nxt = pafit_pkg::S_COMPACT;
        end else begin
          state_nxt = pafit_pkg::S_DONE;
        end
      end

      pafit_pkg::S_COMPACT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wptr_r;
          ram_wdata = rd_q;
        end
        if (ptr_r < cnt_r) begin
          ram_raddr = ptr_r[IW-1:0];
          wptr_nxt  = ptr_back[IW-1:0];
          ptr_nxt   = ptr_inc;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            cnt_nxt   = cnt_r - gap_r;
            state_nxt = pafit_pkg::S_DONE;
          end
        end
      end

      pafit_pkg::S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {res_size_r, res_idx_r, res_addr_r};
          out_tuser_nxt  = res_status_r;
          state_nxt      = pafit_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pafit_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pafit_pkg::S_INIT;
      cnt_r        <= CW'(1);
      fit_mode_r   <= pafit_pkg::FIT_FIRST;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      fit_mode_r   <= fit_mode_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    ptr_r        <= ptr_nxt;
    wptr_r       <= wptr_nxt;
    sum_r        <= sum_nxt;
    start_r      <= start_nxt;
    lo_r         <= lo_nxt;
    src_r        <= src_nxt;
    gap_r        <= gap_nxt;
    tail_r       <= tail_nxt;
    didx_r       <= didx_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_idx_r    <= res_idx_nxt;
    res_size_r   <= res_size_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == pafit_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: rtl/pafit_checker.sv
`include "partition_allocator_fit_assert.svh"

module pafit_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pafit_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [pafit_pkg::STATUS_W-1:0]   out_tuser
);

  // hold a stalled result word
  `PAF_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // one request in flight: drop ready after each accepted word
  `PAF_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // error words carry no region
  `PAF_ASSERT_IMP(a_err_zero, out_tvalid && (out_tuser != pafit_pkg::STAT_OK), out_tdata == '0)

  // successful words carry a nonempty region
  `PAF_ASSERT_IMP(a_ok_size, out_tvalid && (out_tuser == pafit_pkg::STAT_OK), out_tdata[23:14] != '0)

endmodule

bind partition_allocator_fit pafit_checker u_pafit_checker (.*);
